// File: rtl/dlsr_pkg.sv
package dlsr_pkg;

	localparam int MAX_POINTS_DEF = 256;
	localparam int SEG_W = 9;
	localparam logic [SEG_W-1:0] SEG_RESET = 9'd81;
	localparam int SLOPE_W = 17;
	localparam int ICPT_W = 32;
	localparam int OUT_W = 8;
	localparam int FRAC_BITS = 16;
	localparam int ONE_Q16 = 65536;
	localparam int HALF_Q16 = 32768;
	localparam int BOUND_W = 19;
	localparam int BOUND_MAX = 262143;
	localparam int BOUND_MIN = -262144;
	// Quotient bits of the bound division; a bound never exceeds two in magnitude.
	localparam int QUO_W = 20;

	typedef enum logic [1:0] {
		A_HOLD,
		A_SHIFT_IN,
		A_ROTATE
	} a_op_t;

	typedef enum logic [1:0] {
		B_HOLD,
		B_COPY,
		B_ROTATE
	} b_op_t;

	typedef struct packed {
		a_op_t a_op;
		b_op_t b_op;
		logic  in_bit;
	} cell_ctrl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GEN,
		ST_COPY,
		ST_PER_ROT,
		ST_PER_CMP,
		ST_SUM,
		ST_PHASE,
		ST_INV,
		ST_LS,
		ST_FSL,
		ST_LSL,
		ST_MUL,
		ST_NORM,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

// File: rtl/dlsr_cell.sv
module dlsr_cell #(
	parameter int IDX_W = 8,
	parameter int IDX = 0
) (
	input  logic                 clk,
	input  dlsr_pkg::cell_ctrl_t ctrl,
	input  logic [IDX_W-1:0]     last_idx,
	input  logic                 a_next,
	input  logic                 b_next,
	input  logic                 a_head,
	input  logic                 b_head,
	output logic                 a,
	output logic                 b
);
	import dlsr_pkg::*;

	logic a_q;
	logic b_q;
	logic is_last;

	// The cell at the end of the active chain closes the ring or takes the new step.
	assign is_last = (last_idx == IDX_W'(IDX));

	always_ff @(posedge clk) begin
		unique case (ctrl.a_op)
			A_SHIFT_IN: a_q <= is_last ? ctrl.in_bit : a_next;
			A_ROTATE:   a_q <= is_last ? a_head : a_next;
			default:    a_q <= a_q;
		endcase
		unique case (ctrl.b_op)
			B_COPY:   b_q <= a_q;
			B_ROTATE: b_q <= is_last ? b_head : b_next;
			default:  b_q <= b_q;
		endcase
	end

	assign a = a_q;
	assign b = b_q;

endmodule

// File: rtl/dlsr_div.sv
module dlsr_div #(
	parameter int NW = 38,
	parameter int DW = 19,
	parameter int QW = 20
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [QW-1:0] quo,
	output logic          rem_nz
);
	import dlsr_pkg::*;

	localparam int CW = $clog2(QW + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] d_q;
	logic [QW-1:0] sh_q;
	logic [QW-1:0] quo_q;
	logic [DW:0]   rem2;
	logic          ge;

	assign rem2 = {rem_q, sh_q[QW-1]};
	assign ge = (rem2 >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// The upper part of the dividend is already below the divisor, so only
	// the low quotient bits need steps.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DW'(dividend >> QW);
			sh_q  <= dividend[QW-1:0];
			d_q   <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DW'(rem2 - {1'b0, d_q}) : DW'(rem2);
			sh_q  <= sh_q << 1;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo = quo_q;
	assign rem_nz = |rem_q;

endmodule

// File: rtl/digital_line_slope_range_unit.sv
// Takes a slope and intercept, rasterizes n = segment_points - 1 rounded steps
// into a ring of one-bit cells, and returns the period, rise, phase, inverse
// offset and the two slope bounds of the digital segment as one result item.
// One item at a time: it runs the period search (each candidate period rotates
// the whole ring once), the phase search, loading and summing, the leaning
// point walks and the two bound divisions, which share one bit-serial divider.
// The segment length after reset is 81 points.
// A finished result waits in the output register while the next item starts.
module digital_line_slope_range_unit #(
	parameter int MAX_POINTS = dlsr_pkg::MAX_POINTS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [dlsr_pkg::SEG_W-1:0]           cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [dlsr_pkg::SLOPE_W-1:0]         slope_frac,
	input  logic signed [dlsr_pkg::ICPT_W-1:0]   intercept,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [dlsr_pkg::OUT_W-1:0]           period,
	output logic [dlsr_pkg::OUT_W-1:0]           rise,
	output logic [dlsr_pkg::OUT_W-1:0]           phase,
	output logic [dlsr_pkg::OUT_W-1:0]           inverse_offset,
	output logic signed [dlsr_pkg::BOUND_W-1:0]  lower_bound,
	output logic signed [dlsr_pkg::BOUND_W-1:0]  upper_bound,
	output logic                                 lower_valid,
	output logic                                 upper_valid
);
	import dlsr_pkg::*;

	localparam int IW = $clog2(MAX_POINTS);
	localparam int L = MAX_POINTS - 1;
	localparam int AW = ((IW + SLOPE_W > ICPT_W) ? IW + SLOPE_W : ICPT_W) + 2;
	localparam int DDW = IW + 2;
	localparam int PW = 2 * IW + 3;
	localparam int NUMW = PW + 1;
	localparam int NW = 2 * IW + 22;
	localparam int DW = PW;
	localparam int RW = QUO_W + 2;
	localparam logic signed [RW-1:0] R_MAX = RW'(BOUND_MAX);
	localparam logic signed [RW-1:0] R_MIN = RW'(BOUND_MIN);

	state_t state_q, state_d;
	cell_ctrl_t ctrl;

	logic [SEG_W-1:0]  seg_q;
	logic [IW-1:0]     n_q, n_c;
	logic [SLOPE_W-1:0] k_q;
	logic signed [AW-1:0] lo_q, hi_c;
	logic              step_c;
	logic [IW-1:0]     j_q, q_q, p_q, s_q, l_q, r_q, r0_q, v_q;
	logic [IW:0]       x_q, ls_q, fsl_q, lsl_q;
	logic              mis_q, mis_c, mis_n;
	logic              last_j;
	logic              a_head, b_head;
	logic [IW:0]       rs_c, r0_step_c, v_step_c, jq_sum;
	logic              t_c;
	logic [IW+1:0]     xq_sum;
	logic              bsel_q;
	logic signed [DDW-1:0] dd_c;
	logic signed [PW-1:0]  pn_q, pd_q;
	logic              ddz_q;
	logic signed [NUMW-1:0] num_c;
	logic signed [PW-1:0]   den_c;
	logic signed [NW-1:0]   big_c;
	logic              neg_q;
	logic [NW-1:0]     mag_c;
	logic [DW-1:0]     dvs_c;
	logic              div_start, div_done, div_rnz;
	logic [QUO_W-1:0]  div_quo;
	logic signed [RW-1:0] r_c;
	logic signed [BOUND_W-1:0] bnd_c, lob_q, hib_q;
	logic              lov_q, hiv_q;

	logic [L-1:0] a_v, b_v;

	assign cfg_ready = 1'b1;
	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q <= SEG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			seg_q <= cfg_data;
		end
	end

	always_comb begin
		if (seg_q < SEG_W'(3)) begin
			n_c = IW'(2);
		end else if (32'(seg_q) > MAX_POINTS) begin
			n_c = IW'(MAX_POINTS - 1);
		end else begin
			n_c = IW'(seg_q - SEG_W'(1));
		end
	end

	// Ring of cells; cell zero is the read point of both lines.
	for (genvar i = 0; i < L; i++) begin : g_cell
		logic an, bn;
		if (i == L - 1) begin : g_end
			assign an = 1'b0;
			assign bn = 1'b0;
		end else begin : g_mid
			assign an = a_v[i+1];
			assign bn = b_v[i+1];
		end
		dlsr_cell #(.IDX_W(IW), .IDX(i)) u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.last_idx(n_q - IW'(1)),
			.a_next  (an),
			.b_next  (bn),
			.a_head  (a_head),
			.b_head  (b_head),
			.a       (a_v[i]),
			.b       (b_v[i])
		);
	end
	assign a_head = a_v[0];
	assign b_head = b_v[0];

	assign hi_c = lo_q + AW'(signed'({1'b0, k_q}));
	assign step_c = (hi_c[AW-1:FRAC_BITS] != lo_q[AW-1:FRAC_BITS]);
	assign last_j = (j_q == n_q - IW'(1));
	assign jq_sum = {1'b0, j_q} + {1'b0, q_q};
	assign mis_c = (jq_sum < {1'b0, n_q}) && (a_head != b_head);

	// Incremental floor(p*m/q): t is the carry when m steps up by one.
	assign rs_c = {1'b0, r_q} + {1'b0, p_q};
	assign t_c = (rs_c >= {1'b0, q_q});
	assign r0_step_c = {1'b0, r0_q} + {1'b0, q_q} - {1'b0, p_q};
	assign v_step_c = {1'b0, v_q} + {1'b0, p_q};
	assign xq_sum = {1'b0, x_q} + {2'b0, q_q};

	always_comb begin
		mis_n = mis_q;
		if (state_q == ST_PER_CMP) begin
			mis_n = mis_q | mis_c;
		end else if (state_q == ST_PHASE) begin
			mis_n = mis_q | ((j_q < q_q) && (t_c != a_head));
		end
	end

	assign dd_c = bsel_q ? (DDW'(lsl_q) - DDW'(s_q)) : (DDW'(ls_q) - DDW'(fsl_q));

	always_comb begin
		num_c = NUMW'(pn_q) + (bsel_q ? NUMW'(1) : -NUMW'(1));
		den_c = pd_q;
		if (pd_q < 0) begin
			num_c = -num_c;
			den_c = -pd_q;
		end
		big_c = (NW'(num_c) <<< (FRAC_BITS + 1)) + NW'(den_c);
		mag_c = big_c[NW-1] ? NW'(-big_c) : NW'(big_c);
		dvs_c = DW'(den_c) << 1;
	end

	assign div_start = (state_q == ST_NORM) && !ddz_q;

	dlsr_div #(.NW(NW), .DW(DW), .QW(QUO_W)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(mag_c),
		.divisor (dvs_c),
		.done    (div_done),
		.quo     (div_quo),
		.rem_nz  (div_rnz)
	);

	always_comb begin
		r_c = neg_q ? -(RW'(div_quo) + RW'(div_rnz)) : RW'(div_quo);
		if (r_c > R_MAX) begin
			bnd_c = BOUND_W'(BOUND_MAX);
		end else if (r_c < R_MIN) begin
			bnd_c = BOUND_W'(BOUND_MIN);
		end else begin
			bnd_c = BOUND_W'(r_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ctrl.a_op = A_HOLD;
		ctrl.b_op = B_HOLD;
		ctrl.in_bit = step_c;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_GEN;
			end
			ST_GEN: begin
				ctrl.a_op = A_SHIFT_IN;
				if (last_j) state_d = ST_COPY;
			end
			ST_COPY: begin
				ctrl.b_op = B_COPY;
				state_d = ST_PER_ROT;
			end
			ST_PER_ROT: begin
				ctrl.b_op = B_ROTATE;
				state_d = ST_PER_CMP;
			end
			ST_PER_CMP: begin
				ctrl.a_op = A_ROTATE;
				ctrl.b_op = B_ROTATE;
				if (last_j) state_d = (!mis_n || q_q == n_q) ? ST_SUM : ST_PER_ROT;
			end
			ST_SUM: begin
				ctrl.a_op = A_ROTATE;
				if (last_j) state_d = ST_PHASE;
			end
			ST_PHASE: begin
				ctrl.a_op = A_ROTATE;
				if (last_j && (!mis_n || s_q + IW'(1) == q_q)) state_d = ST_INV;
			end
			ST_INV: begin
				if (l_q == q_q || v_q == '0) state_d = ST_LS;
			end
			ST_LS: begin
				if (xq_sum > {2'b0, n_q}) state_d = ST_FSL;
			end
			ST_FSL: begin
				if (x_q < {1'b0, q_q}) state_d = ST_LSL;
			end
			ST_LSL: begin
				if (xq_sum > {2'b0, n_q}) state_d = ST_MUL;
			end
			ST_MUL: state_d = ST_NORM;
			ST_NORM: begin
				if (ddz_q) state_d = bsel_q ? ST_DONE : ST_MUL;
				else state_d = ST_DIV;
			end
			ST_DIV: begin
				if (div_done) state_d = bsel_q ? ST_DONE : ST_MUL;
			end
			ST_DONE: begin
				if (!out_valid || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid || out_ready)) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid || out_ready)) begin
			period         <= OUT_W'(q_q);
			rise           <= OUT_W'(p_q);
			phase          <= OUT_W'(s_q);
			inverse_offset <= OUT_W'(l_q);
			lower_bound    <= lob_q;
			upper_bound    <= hib_q;
			lower_valid    <= lov_q;
			upper_valid    <= hiv_q;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				n_q <= n_c;
				k_q <= (slope_frac > SLOPE_W'(ONE_Q16)) ? SLOPE_W'(ONE_Q16) : slope_frac;
				lo_q <= AW'(intercept) + AW'(HALF_Q16);
				j_q <= '0;
			end
			ST_GEN: begin
				lo_q <= hi_c;
				j_q <= last_j ? '0 : j_q + IW'(1);
			end
			ST_COPY: q_q <= IW'(1);
			ST_PER_ROT: mis_q <= 1'b0;
			ST_PER_CMP: begin
				mis_q <= mis_n;
				j_q <= last_j ? '0 : j_q + IW'(1);
				if (last_j) begin
					if (!mis_n || q_q == n_q) p_q <= '0;
					else q_q <= q_q + IW'(1);
				end
			end
			ST_SUM: begin
				if (j_q < q_q) p_q <= p_q + IW'(a_head);
				j_q <= last_j ? '0 : j_q + IW'(1);
				if (last_j) begin
					s_q <= '0;
					r_q <= '0;
					r0_q <= '0;
					mis_q <= 1'b0;
				end
			end
			ST_PHASE: begin
				mis_q <= last_j ? 1'b0 : mis_n;
				j_q <= last_j ? '0 : j_q + IW'(1);
				if (last_j && mis_n) begin
					// Start value of the next offset: -(s+1)*p modulo q.
					r_q <= (r0_q >= p_q) ? r0_q - p_q : IW'(r0_step_c);
				end else if (j_q < q_q) begin
					r_q <= IW'(t_c ? rs_c - {1'b0, q_q} : rs_c);
				end
				if (last_j) begin
					l_q <= '0;
					v_q <= (q_q == IW'(1)) ? '0 : IW'(1);
					if (mis_n) begin
						s_q <= s_q + IW'(1);
						r0_q <= (r0_q >= p_q) ? r0_q - p_q : IW'(r0_step_c);
					end
				end
			end
			ST_INV: begin
				if (l_q == q_q || v_q == '0) begin
					x_q <= {1'b0, s_q};
				end else begin
					l_q <= l_q + IW'(1);
					v_q <= IW'((v_step_c >= {1'b0, q_q}) ? v_step_c - {1'b0, q_q} : v_step_c);
				end
			end
			ST_LS: begin
				if (xq_sum > {2'b0, n_q}) begin
					ls_q <= x_q;
					x_q <= {1'b0, s_q} + {1'b0, l_q};
				end else begin
					x_q <= IW'(0) + (IW+1)'(xq_sum);
				end
			end
			ST_FSL: begin
				if (x_q < {1'b0, q_q}) fsl_q <= x_q;
				else x_q <= x_q - {1'b0, q_q};
			end
			ST_LSL: begin
				bsel_q <= 1'b0;
				if (xq_sum > {2'b0, n_q}) lsl_q <= x_q;
				else x_q <= (IW+1)'(xq_sum);
			end
			ST_MUL: begin
				pn_q <= PW'(signed'({1'b0, p_q}) * dd_c);
				pd_q <= PW'(signed'({1'b0, q_q}) * dd_c);
				ddz_q <= (dd_c == '0);
			end
			ST_NORM: begin
				neg_q <= big_c[NW-1];
				if (ddz_q) begin
					if (bsel_q) begin
						hib_q <= BOUND_W'(BOUND_MAX);
						hiv_q <= 1'b0;
					end else begin
						lob_q <= BOUND_W'(BOUND_MIN);
						lov_q <= 1'b0;
					end
					bsel_q <= 1'b1;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					if (bsel_q) begin
						hib_q <= bnd_c;
						hiv_q <= 1'b1;
					end else begin
						lob_q <= bnd_c;
						lov_q <= 1'b1;
					end
					bsel_q <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: tb/tb_digital_line_slope_range_unit.sv
module tb_digital_line_slope_range_unit;
	import dlsr_pkg::*;

	localparam longint CYCLE_LIMIT = 40000000;

	typedef struct packed {
		logic [OUT_W-1:0]          period;
		logic [OUT_W-1:0]          rise;
		logic [OUT_W-1:0]          phase;
		logic [OUT_W-1:0]          inverse_offset;
		logic signed [BOUND_W-1:0] lower_bound;
		logic signed [BOUND_W-1:0] upper_bound;
		logic                      lower_valid;
		logic                      upper_valid;
	} segment_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [SEG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [SLOPE_W-1:0] slope_frac = '0;
	logic signed [ICPT_W-1:0] intercept = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [OUT_W-1:0] period, rise, phase, inverse_offset;
	logic signed [BOUND_W-1:0] lower_bound, upper_bound;
	logic lower_valid, upper_valid;

	logic [SEG_W-1:0] seg_points = SEG_RESET;
	segment_t expected_segments[$];
	int errors = 0;
	longint cycles = 0;
	bit idling = 1'b1;

	digital_line_slope_range_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.slope_frac(slope_frac), .intercept(intercept),
		.out_valid(out_valid), .out_ready(out_ready),
		.period(period), .rise(rise), .phase(phase), .inverse_offset(inverse_offset),
		.lower_bound(lower_bound), .upper_bound(upper_bound),
		.lower_valid(lower_valid), .upper_valid(upper_valid)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint fdiv(longint a, longint d);
		longint r;
		r = a / d;
		if ((a % d) != 0 && a < 0)
			r = r - 1;
		return r;
	endfunction

	// Returns the valid bit above the 19-bit bound.
	function automatic logic [BOUND_W:0] slope_bound(longint p, longint q, longint dd,
			longint sgn);
		longint num, den, r;
		if (dd == 0)
			return {1'b0, (sgn < 0) ? 19'(BOUND_MIN) : 19'(BOUND_MAX)};
		num = p * dd + sgn;
		den = q * dd;
		if (den < 0) begin
			num = -num;
			den = -den;
		end
		r = fdiv(2 * longint'(ONE_Q16) * num + den, 2 * den);
		if (r > BOUND_MAX) r = BOUND_MAX;
		if (r < BOUND_MIN) r = BOUND_MIN;
		return {1'b1, 19'(r)};
	endfunction

	function automatic segment_t predict_segment(logic [SLOPE_W-1:0] kin,
			logic signed [ICPT_W-1:0] bin);
		longint k, b, n, q, p, s, l, i, j, pts, lo, ls, fsl, lsl, t;
		bit chain[MAX_POINTS_DEF];
		bit ok;
		logic [BOUND_W:0] lb, ub;
		segment_t r;
		k = kin;
		if (k > ONE_Q16) k = ONE_Q16;
		b = bin;
		pts = seg_points;
		if (pts < 3) pts = 3;
		if (pts > MAX_POINTS_DEF) pts = MAX_POINTS_DEF;
		n = pts - 1;
		for (i = 0; i < n; i++) begin
			lo = k * i + b + HALF_Q16 + (longint'(1) << 40);
			chain[i] = (((lo + k) >>> 16) - (lo >>> 16)) != 0;
		end
		for (q = 1; q <= n; q++) begin
			ok = 1'b1;
			for (j = 0; j + q < n; j++)
				if (chain[j] != chain[j+q]) begin
					ok = 1'b0;
					break;
				end
			if (ok) break;
		end
		if (q > n) q = n;
		p = 0;
		for (i = 0; i < q; i++)
			p += chain[i];
		for (s = 0; s < q; s++) begin
			ok = 1'b1;
			for (i = 1; i <= q; i++) begin
				t = fdiv(p * (i - s), q) - fdiv(p * (i - s - 1), q);
				if (longint'(chain[i-1]) != t) begin
					ok = 1'b0;
					break;
				end
			end
			if (ok) break;
		end
		for (l = 0; l < q; l++)
			if ((l * p + 1) % q == 0) break;
		ls = s + fdiv(n - s, q) * q;
		fsl = s + l - fdiv(s + l, q) * q;
		lsl = s + l + fdiv(n - s - l, q) * q;
		lb = slope_bound(p, q, ls - fsl, -1);
		ub = slope_bound(p, q, lsl - s, 1);
		r.period = q[7:0];
		r.rise = p[7:0];
		r.phase = s[7:0];
		r.inverse_offset = l[7:0];
		r.lower_bound = lb[BOUND_W-1:0];
		r.lower_valid = lb[BOUND_W];
		r.upper_bound = ub[BOUND_W-1:0];
		r.upper_valid = ub[BOUND_W];
		return r;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	always @(posedge clk) begin
		segment_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_segments.size() == 0) begin
				$display("unexpected result item at cycle %0d", cycles);
				errors++;
			end else begin
				e = expected_segments.pop_front();
				if (period !== e.period) report_mismatch("period", period, e.period);
				if (rise !== e.rise) report_mismatch("rise", rise, e.rise);
				if (phase !== e.phase) report_mismatch("phase", phase, e.phase);
				if (inverse_offset !== e.inverse_offset)
					report_mismatch("inverse_offset", inverse_offset, e.inverse_offset);
				if (lower_bound !== e.lower_bound)
					report_mismatch("lower_bound", lower_bound, e.lower_bound);
				if (upper_bound !== e.upper_bound)
					report_mismatch("upper_bound", upper_bound, e.upper_bound);
				if (lower_valid !== e.lower_valid)
					report_mismatch("lower_valid", lower_valid, e.lower_valid);
				if (upper_valid !== e.upper_valid)
					report_mismatch("upper_valid", upper_valid, e.upper_valid);
			end
		end
	end

	always @(posedge clk) begin
		out_ready <= idling ? ($urandom_range(99) >= 15) : 1'b1;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// The valid line stays high between back-to-back items and is lowered only for a gap.
	task automatic send_line(logic [SLOPE_W-1:0] k, logic signed [ICPT_W-1:0] b);
		if (idling && $urandom_range(99) < 15) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 50);
		end
		slope_frac <= k;
		intercept <= b;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		expected_segments.push_back(predict_segment(k, b));
	endtask

	task automatic drain;
		in_valid <= 1'b0;
		while (expected_segments.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_points(logic [SEG_W-1:0] v);
		drain();
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		seg_points = v;
	endtask

	task automatic test_directed;
		send_line(17'd0, 32'sd0);
		send_line(17'd65536, -32'sd2147483648);
		send_line(17'h1FFFF, 32'sd2147483647);
		send_line(17'd32768, -32'sd1);
		send_line(17'd21845, 32'sd32768);
		send_line(17'd40503, 32'sd12345);
		send_line(17'd65535, 32'h7FFF_0000);
		send_line(17'h10001, 32'h8000_FFFF);
	endtask

	task automatic test_lengths;
		write_points(9'd0);
		send_line(17'd30000, 32'sd100);
		send_line(17'd65536, 32'sd0);
		write_points(9'd3);
		send_line(17'd45000, -32'sd70000);
		write_points(9'd511);
		send_line(17'd40503, 32'sd5000);
		send_line(17'd0, -32'sd1);
		write_points(9'd256);
		send_line(17'd16384, 32'sd0);
		send_line(17'd65536, 32'sd7);
		write_points(9'd2);
		send_line(17'd50000, 32'sd1);
	endtask

	task automatic test_random;
		int it;
		logic [SLOPE_W-1:0] k;
		for (int phase_no = 0; phase_no < 10; phase_no++) begin
			if (phase_no == 9) write_points(9'($urandom_range(200, 256)));
			else write_points(9'($urandom_range(3, 40)));
			idling = (phase_no != 4);
			for (it = 0; it < ((phase_no == 9) ? 2 : 11); it++) begin
				case ($urandom_range(3))
					0: k = 17'($urandom);
					1: k = 17'($urandom_range(ONE_Q16));
					2: k = $urandom_range(1) ? 17'd0 : 17'd65536;
					default: k = 17'($urandom_range(ONE_Q16 / 4));
				endcase
				send_line(k, $urandom_range(1) ? 32'($urandom) : 32'($urandom_range(131071)));
			end
		end
		idling = 1'b1;
		write_points(SEG_RESET);
		send_line(17'($urandom_range(ONE_Q16)), 32'($urandom));
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_lengths();
		test_random();
		drain();
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
